@@ design/hcp_pkg.sv @@
// shared types and constants for the hex color string parser
package hcp_pkg;

    localparam logic [7:0] HASH_CHAR    = 8'h23;
    localparam logic [7:0] NUL_CHAR     = 8'h00;
    localparam logic [7:0] SPACE_CHAR   = 8'h20;
    localparam logic [7:0] TAB_CHAR     = 8'h09;
    localparam logic [7:0] CR_CHAR      = 8'h0d;
    localparam logic [2:0] SHORT_DIGITS = 3'd3;
    localparam logic [2:0] LONG_DIGITS  = 3'd6;

    typedef enum logic [1:0] {
        PH_LEAD  = 2'd0,
        PH_BODY  = 2'd1,
        PH_TRAIL = 2'd2,
        PH_FAIL  = 2'd3
    } t_phase;

    typedef struct packed {
        logic       is_nul;
        logic       is_blank;
        logic       is_hash;
        logic       is_hex;
        logic [3:0] value;
    } t_char_class;

    typedef struct packed {
        logic       ok;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_result;

endpackage

@@ design/hcp_char_class.sv @@
// character classifier: whitespace, hash, nul and hex digit decode
module hcp_char_class (
    input  logic [7:0]          i_char,
    output hcp_pkg::t_char_class o_class
);

    always_comb begin
        o_class          = '0;
        o_class.is_nul   = (i_char == hcp_pkg::NUL_CHAR);
        o_class.is_hash  = (i_char == hcp_pkg::HASH_CHAR);
        o_class.is_blank = ((i_char >= hcp_pkg::TAB_CHAR) && (i_char <= hcp_pkg::CR_CHAR))
                           || (i_char == hcp_pkg::SPACE_CHAR);
        if ((i_char >= 8'h30) && (i_char <= 8'h39)) begin
            o_class.is_hex = 1'b1;
            o_class.value  = 4'(i_char - 8'h30);
        end else if ((i_char >= 8'h61) && (i_char <= 8'h66)) begin
            o_class.is_hex = 1'b1;
            o_class.value  = 4'(i_char - 8'h57);
        end else if ((i_char >= 8'h41) && (i_char <= 8'h46)) begin
            o_class.is_hex = 1'b1;
            o_class.value  = 4'(i_char - 8'h37);
        end
    end

endmodule

@@ design/hcp_parse_core.sv @@
// parse state: character count, phase, digit count and digit shift register
module hcp_parse_core #(
    parameter int BUFFER_BYTES = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_eot,
    input  hcp_pkg::t_char_class i_class,
    output hcp_pkg::t_result     o_result
);

    localparam int CW = $clog2(BUFFER_BYTES);
    localparam logic [CW-1:0] LIMIT = CW'(BUFFER_BYTES - 1);

    hcp_pkg::t_phase r_phase, n_phase;
    logic [CW-1:0]   r_count, n_count;
    logic [2:0]      r_digits, n_digits;
    logic [23:0]     r_bits, n_bits;

    logic counted;
    logic take_hex;

    // a byte counts when the buffer is not full and it is not the terminator
    assign counted  = (r_count < LIMIT) && !i_class.is_nul;
    assign take_hex = i_class.is_hex &&
                      ((r_phase == hcp_pkg::PH_LEAD) || (r_phase == hcp_pkg::PH_BODY));

    // phase next state
    always_comb begin
        n_phase = r_phase;
        if (i_step) begin
            if (i_eot) begin
                n_phase = hcp_pkg::PH_LEAD;
            end else if (counted) begin
                unique case (r_phase)
                    hcp_pkg::PH_LEAD: begin
                        if (i_class.is_blank) begin
                            n_phase = hcp_pkg::PH_LEAD;
                        end else if (i_class.is_hash) begin
                            n_phase = hcp_pkg::PH_BODY;
                        end else if (i_class.is_hex) begin
                            n_phase = (r_digits >= hcp_pkg::LONG_DIGITS) ?
                                      hcp_pkg::PH_FAIL : hcp_pkg::PH_BODY;
                        end else begin
                            n_phase = hcp_pkg::PH_FAIL;
                        end
                    end
                    hcp_pkg::PH_BODY: begin
                        if (i_class.is_blank) begin
                            n_phase = hcp_pkg::PH_TRAIL;
                        end else if (i_class.is_hex) begin
                            n_phase = (r_digits >= hcp_pkg::LONG_DIGITS) ?
                                      hcp_pkg::PH_FAIL : hcp_pkg::PH_BODY;
                        end else begin
                            n_phase = hcp_pkg::PH_FAIL;
                        end
                    end
                    hcp_pkg::PH_TRAIL: begin
                        n_phase = i_class.is_blank ? hcp_pkg::PH_TRAIL : hcp_pkg::PH_FAIL;
                    end
                    default: begin
                        n_phase = hcp_pkg::PH_FAIL;
                    end
                endcase
            end
        end
    end

    // counters and digit register
    always_comb begin
        n_count  = r_count;
        n_digits = r_digits;
        n_bits   = r_bits;
        if (i_step) begin
            if (i_eot) begin
                n_count  = '0;
                n_digits = '0;
                n_bits   = '0;
            end else if (r_count < LIMIT) begin
                if (i_class.is_nul) begin
                    n_count = LIMIT;
                end else begin
                    n_count = r_count + 1'b1;
                    if (take_hex && (r_digits < hcp_pkg::LONG_DIGITS)) begin
                        n_digits = r_digits + 3'd1;
                        n_bits   = {r_bits[19:0], i_class.value};
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= hcp_pkg::PH_LEAD;
            r_count  <= '0;
            r_digits <= '0;
            r_bits   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_digits <= n_digits;
            r_bits   <= n_bits;
        end
    end

    // result from the current state, used on the end marker
    always_comb begin
        o_result = '0;
        if (r_phase != hcp_pkg::PH_FAIL) begin
            if (r_digits == hcp_pkg::SHORT_DIGITS) begin
                o_result.ok    = 1'b1;
                o_result.red   = {r_bits[11:8], r_bits[11:8]};
                o_result.green = {r_bits[7:4], r_bits[7:4]};
                o_result.blue  = {r_bits[3:0], r_bits[3:0]};
            end else if (r_digits == hcp_pkg::LONG_DIGITS) begin
                o_result.ok    = 1'b1;
                o_result.red   = r_bits[23:16];
                o_result.green = r_bits[15:8];
                o_result.blue  = r_bits[7:0];
            end
        end
    end

endmodule

@@ design/hcp_out_reg.sv @@
// result register with valid and ready
module hcp_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  hcp_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_valid,
    output logic             o_free,
    output hcp_pkg::t_result o_result
);

    logic             r_valid, n_valid;
    hcp_pkg::t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ design/hex_color_string_parser_top.sv @@
// top level of the hex color string parser
// Parses a color text sent one character per transaction and closed by a
// transaction with end_of_text set. Up to BUFFER_BYTES-1 characters count; a
// nul byte ends the counted text early. Leading and trailing whitespace is
// dropped, an optional '#' may lead, then exactly 3 or 6 hex digits must
// follow; 3 digits are doubled. The end marker yields one result transaction
// (ok, red, green, blue; colors zero when ok is 0) and clears the parser.
// Rate: one transaction per cycle sustained while no end marker waits. Each
// accepted transaction sits in the input register until it advances and the
// parse state updates; the result register loads when the end marker leaves
// the input register. An end marker waits in the input register only while a
// previous result is held by an output side that is not ready.
module hex_color_string_parser_top #(
    parameter int BUFFER_BYTES = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_character,
    input  logic       i_end_of_text,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_ok,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue
);

    // input register
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_char;
    logic       r_eot;

    logic                 advance;
    logic                 out_free;
    logic                 in_take;
    hcp_pkg::t_char_class char_class;
    hcp_pkg::t_result     parse_result;
    hcp_pkg::t_result     out_result;

    // a character always advances; an end marker needs room for its result
    assign advance    = r_in_valid && (!r_eot || out_free);
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_char <= i_character;
            r_eot  <= i_end_of_text;
        end
    end

    hcp_char_class u_class (
        .i_char  (r_char),
        .o_class (char_class)
    );

    hcp_parse_core #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_eot    (r_eot),
        .i_class  (char_class),
        .o_result (parse_result)
    );

    // result register, loaded when an end marker advances
    hcp_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && r_eot),
        .i_result (parse_result),
        .i_ready  (i_out_ready),
        .o_valid  (o_out_valid),
        .o_free   (out_free),
        .o_result (out_result)
    );

    assign o_ok    = out_result.ok;
    assign o_red   = out_result.red;
    assign o_green = out_result.green;
    assign o_blue  = out_result.blue;

endmodule

@@ design/hcp_checker.sv @@
// port level checker for the hex color string parser, bound to the top level
module hcp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_ok,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue
);

    // result held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped before transaction");

    // stalled result payload unchanged
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        ($stable(o_ok) && $stable(o_red) && $stable(o_green) && $stable(o_blue)))
        else $error("result payload changed while stalled");

    // failed parse gives black
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |-> ((o_red == 8'h00) && (o_green == 8'h00)
        && (o_blue == 8'h00)))
        else $error("nonzero color on failed parse");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // input never stalls while no result is held
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule

bind hex_color_string_parser_top hcp_checker u_hcp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_ok        (o_ok),
    .o_red       (o_red),
    .o_green     (o_green),
    .o_blue      (o_blue)
);

@@ tb/testbench.sv @@
// self-checking testbench for the hex color string parser
module testbench;

    localparam int BUFFER_BYTES = 32;
    localparam int ITEM_TARGET  = 1050;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    // cycle window with no idling on either side
    localparam int QUIET_FROM   = 300;
    localparam int QUIET_TO     = 700;

    localparam logic [7:0] DIGIT_ZERO = "0";
    localparam logic [7:0] LOWER_A    = "a";
    localparam logic [7:0] UPPER_A    = "A";

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } t_text_item;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_character = '0;
    logic       i_end_of_text = 1'b0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_ok;
    logic [7:0] o_red;
    logic [7:0] o_green;
    logic [7:0] o_blue;

    hex_color_string_parser_top #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_character  (i_character),
        .i_end_of_text(i_end_of_text),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_ok         (o_ok),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    always #2 i_clk = ~i_clk;

    // stimulus and scoreboard storage
    t_text_item       pending_items[$];
    t_text_item       next_item;
    logic [7:0]       text_buf[$];
    hcp_pkg::t_result color_expect[$];

    int cycle_count = 0;
    int error_count = 0;
    int texts_queued = 0;
    int chars_queued = 0;
    int results_seen = 0;
    int colors_seen = 0;

    // parser model state
    int              chars_counted;
    hcp_pkg::t_phase parse_phase;
    logic [2:0]      digits_held;
    logic [23:0]     digit_nibbles;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // random idle decision, suppressed inside the quiet window
    function automatic logic take_break();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
        return $urandom_range(99) < 14;
    endfunction

    // 0..15 for a hex digit, 16 for anything else
    function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
        if (ch >= DIGIT_ZERO && ch <= DIGIT_ZERO + 8'd9) return {1'b0, 4'(ch - DIGIT_ZERO)};
        if (ch >= LOWER_A && ch <= LOWER_A + 8'd5) return {1'b0, 4'(ch - LOWER_A + 8'd10)};
        if (ch >= UPPER_A && ch <= UPPER_A + 8'd5) return {1'b0, 4'(ch - UPPER_A + 8'd10)};
        return 5'd16;
    endfunction

    task automatic clear_parser();
        chars_counted = 0;
        parse_phase   = hcp_pkg::PH_LEAD;
        digits_held   = '0;
        digit_nibbles = '0;
    endtask

    task automatic take_nibble(input logic [3:0] nib);
        if (digits_held >= hcp_pkg::LONG_DIGITS) begin
            parse_phase = hcp_pkg::PH_FAIL;
            return;
        end
        digit_nibbles = {digit_nibbles[19:0], nib};
        digits_held   = digits_held + 3'd1;
        parse_phase   = hcp_pkg::PH_BODY;
    endtask

    // advance the parser model by one accepted transaction
    task automatic absorb_item(input logic [7:0] ch, input logic eot);
        hcp_pkg::t_result res;
        logic [4:0]       nib;
        logic             blank;
        if (eot) begin
            res = '0;
            if (parse_phase != hcp_pkg::PH_FAIL) begin
                if (digits_held == hcp_pkg::SHORT_DIGITS) begin
                    res.ok    = 1'b1;
                    res.red   = {2{digit_nibbles[11:8]}};
                    res.green = {2{digit_nibbles[7:4]}};
                    res.blue  = {2{digit_nibbles[3:0]}};
                end else if (digits_held == hcp_pkg::LONG_DIGITS) begin
                    res.ok    = 1'b1;
                    res.red   = digit_nibbles[23:16];
                    res.green = digit_nibbles[15:8];
                    res.blue  = digit_nibbles[7:0];
                end
            end
            color_expect.push_back(res);
            clear_parser();
            return;
        end
        if (chars_counted >= BUFFER_BYTES - 1) return;
        // nul acts as a string terminator: everything after it is dropped
        if (ch == hcp_pkg::NUL_CHAR) begin
            chars_counted = BUFFER_BYTES - 1;
            return;
        end
        chars_counted++;
        if (parse_phase == hcp_pkg::PH_FAIL) return;
        nib   = hex_nibble(ch);
        blank = (ch >= hcp_pkg::TAB_CHAR && ch <= hcp_pkg::CR_CHAR)
                || ch == hcp_pkg::SPACE_CHAR;
        case (parse_phase)
            hcp_pkg::PH_LEAD: begin
                if (blank) begin
                end else if (ch == hcp_pkg::HASH_CHAR) begin
                    parse_phase = hcp_pkg::PH_BODY;
                end else if (!nib[4]) begin
                    take_nibble(nib[3:0]);
                end else begin
                    parse_phase = hcp_pkg::PH_FAIL;
                end
            end
            hcp_pkg::PH_BODY: begin
                if (blank) begin
                    parse_phase = hcp_pkg::PH_TRAIL;
                end else if (!nib[4]) begin
                    take_nibble(nib[3:0]);
                end else begin
                    parse_phase = hcp_pkg::PH_FAIL;
                end
            end
            default: begin
                // anything but whitespace after the trailing blanks is inner whitespace
                if (!blank) parse_phase = hcp_pkg::PH_FAIL;
            end
        endcase
    endtask

    // driver: holds each transaction until accepted, idles at random between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            clear_parser();
        end else begin
            if (i_in_valid && o_in_ready) absorb_item(i_character, i_end_of_text);
            if (!i_in_valid || o_in_ready) begin
                if (pending_items.size() != 0 && !take_break()) begin
                    next_item = pending_items.pop_front();
                    i_in_valid    <= 1'b1;
                    i_character   <= next_item.ch;
                    i_end_of_text <= next_item.eot;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            error_count++;
        end
    endtask

    // monitor: compares each result transaction with the oldest expected color
    always @(posedge i_clk) begin
        i_out_ready <= !take_break();
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (color_expect.size() == 0) begin
                $error("result transaction with nothing expected: ok %0d rgb %0d %0d %0d",
                       o_ok, o_red, o_green, o_blue);
                error_count++;
            end else begin
                check_field("ok", int'(color_expect[0].ok), int'(o_ok));
                check_field("red", int'(color_expect[0].red), int'(o_red));
                check_field("green", int'(color_expect[0].green), int'(o_green));
                check_field("blue", int'(color_expect[0].blue), int'(o_blue));
                if (color_expect[0].ok) colors_seen++;
                void'(color_expect.pop_front());
            end
            results_seen++;
        end
    end

    // move text_buf into the pending queue, closed by an end marker
    task automatic queue_text();
        t_text_item it;
        foreach (text_buf[k]) begin
            it.ch  = text_buf[k];
            it.eot = 1'b0;
            pending_items.push_back(it);
        end
        // the byte carried by the end marker is ignored, so it is random
        it.ch  = 8'($urandom);
        it.eot = 1'b1;
        pending_items.push_back(it);
        chars_queued += text_buf.size();
        texts_queued++;
        text_buf.delete();
    endtask

    function automatic logic [7:0] rand_blank();
        int k;
        k = $urandom_range(5);
        if (k == 5) return hcp_pkg::SPACE_CHAR;
        return hcp_pkg::TAB_CHAR + 8'(k);
    endfunction

    function automatic logic [7:0] rand_hex();
        int v;
        v = $urandom_range(15);
        if (v < 10) return DIGIT_ZERO + 8'(v);
        return ($urandom_range(1) ? LOWER_A : UPPER_A) + 8'(v - 10);
    endfunction

    // optional blanks, optional hash, 3 or 6 digits, optional blanks
    task automatic build_color();
        int n;
        n = $urandom_range(3);
        repeat (n) text_buf.push_back(rand_blank());
        if ($urandom_range(1)) text_buf.push_back(hcp_pkg::HASH_CHAR);
        n = $urandom_range(1) ? 6 : 3;
        repeat (n) text_buf.push_back(rand_hex());
        n = $urandom_range(3);
        repeat (n) text_buf.push_back(rand_blank());
    endtask

    task automatic load_string(input string s);
        for (int k = 0; k < s.len(); k++) text_buf.push_back(s[k]);
    endtask

    initial begin : stimulus
        int pick;
        int pos;
        int n;

        // directed texts
        load_string("#fA0");
        queue_text();
        load_string(" 9aF0Bd");
        text_buf.push_back(hcp_pkg::CR_CHAR);
        queue_text();
        queue_text();                          // empty text
        load_string("#");
        queue_text();
        text_buf.push_back(hcp_pkg::HASH_CHAR);
        text_buf.push_back(hcp_pkg::NUL_CHAR); // terminator hides what follows
        load_string("zz");
        queue_text();
        load_string("##1");
        queue_text();
        text_buf.push_back(8'hff);
        queue_text();

        // random texts, mostly well formed
        while (pending_items.size() < ITEM_TARGET) begin
            pick = $urandom_range(99);
            if (pick < 62) begin
                build_color();
            end else if (pick < 80) begin
                // broken color: one mutation at a random place
                build_color();
                pos = $urandom_range(text_buf.size());
                case ($urandom_range(5))
                    0: text_buf.insert(pos, 8'($urandom));
                    1: text_buf.insert(pos, rand_hex());
                    2: text_buf.insert(pos, hcp_pkg::HASH_CHAR);
                    3: text_buf.insert(pos, hcp_pkg::NUL_CHAR);
                    4: text_buf.insert(pos, rand_blank());
                    default: begin
                        if (text_buf.size() != 0)
                            text_buf.delete($urandom_range(text_buf.size() - 1));
                    end
                endcase
            end else if (pick < 88) begin
                // overlong text: body pushed toward or past the counted limit
                if ($urandom_range(1)) begin
                    n = $urandom_range(24, 30);
                    repeat (n) text_buf.push_back(hcp_pkg::SPACE_CHAR);
                end
                build_color();
                n = BUFFER_BYTES - 1 + $urandom_range(6);
                while (text_buf.size() < n) text_buf.push_back(rand_blank());
                n = $urandom_range(5);
                repeat (n) text_buf.push_back(8'($urandom));
            end else begin
                // noise drawn from the byte classes the parser cares about
                n = $urandom_range(8);
                repeat (n) begin
                    case ($urandom_range(3))
                        0: text_buf.push_back(8'($urandom));
                        1: text_buf.push_back(rand_hex());
                        2: text_buf.push_back(hcp_pkg::HASH_CHAR);
                        default: text_buf.push_back(rand_blank());
                    endcase
                end
            end
            queue_text();
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_in_valid || color_expect.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d texts with %0d characters in total", texts_queued, chars_queued);
        $display("checked %0d results, %0d of them valid colors", results_seen, colors_seen);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles", cycle_count);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ hex_color_string_parser_top.f @@
design/hcp_pkg.sv
design/hcp_char_class.sv
design/hcp_parse_core.sv
design/hcp_out_reg.sv
design/hex_color_string_parser_top.sv
design/hcp_checker.sv
tb/testbench.sv
